@@ hw/rtl/wcq_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package wcq_pkg;

	// default sizes
	localparam int ELEMENTS_DEF    = 1024;
	localparam int CLUSTERINGS_DEF = 16;
	localparam int LABELS_DEF      = 16;

	// field widths
	localparam int ACT_W  = 2;
	localparam int CLUS_W = 4;
	localparam int ELEM_W = 10;
	localparam int LAB_W  = 5;
	localparam int WGT_W  = 17;
	localparam int DIST_W = 7;
	localparam int CFG_W  = 5;

	// q1.16 weights
	localparam int                 WEIGHT_FRAC = 16;
	localparam logic [WGT_W-1:0]   WEIGHT_ONE  = 17'h10000;
	localparam logic [DIST_W-1:0]  PERCENT     = 7'd100;

	// action codes of an input item
	localparam logic [ACT_W-1:0] ACT_LABEL  = 2'd0;
	localparam logic [ACT_W-1:0] ACT_WEIGHT = 2'd1;
	localparam logic [ACT_W-1:0] ACT_QUERY  = 2'd2;

	// command queue
	localparam int QDEPTH = 2;
	localparam int QPW    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCW    = $clog2(QDEPTH + 1);

	typedef struct packed {
		logic [ACT_W-1:0]  action;
		logic [CLUS_W-1:0] clustering_index;
		logic [ELEM_W-1:0] element_a;
		logic [ELEM_W-1:0] element_b;
		logic [LAB_W-1:0]  label;
		logic [WGT_W-1:0]  weight;
	} wcq_in_t;

	typedef struct packed {
		logic [DIST_W-1:0] distance;
		logic [ELEM_W-1:0] pair_row;
		logic [ELEM_W-1:0] pair_col;
	} wcq_out_t;

	typedef enum logic [1:0] {
		OP_LABEL,
		OP_WEIGHT,
		OP_QUERY
	} wcq_op_t;

	// classified command, front to back
	typedef struct packed {
		wcq_op_t           op;
		logic [CLUS_W-1:0] clus;
		logic [ELEM_W-1:0] elem_a;
		logic [ELEM_W-1:0] elem_b;
		logic [LAB_W-1:0]  lab_idx;
		logic [WGT_W-1:0]  weight;
		logic              live;
	} wcq_cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} wcq_qstat_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_MUL,
		ST_DIV
	} wcq_state_t;

endpackage

`default_nettype wire

@@ hw/rtl/weighted_coassociation_query_top.sv @@
`timescale 1ns / 1ps
`default_nettype none

// weighted co-association query engine
//
// item channel: an item transfers at a rising edge with start high and busy low.
// label and weight writes load the two stores; a query names two elements and
// returns one result, writes and dropped items return nothing.
// result channel: result_valid is high for exactly one cycle per query and the
// result transfers at the edge ending that cycle; the receiver cannot stall it.
// config channel: cfg_data (clusterings in use) transfers on cfg_valid and
// cfg_ready, and cfg_ready is always high; write it only while the block is idle.
// a query, with n the clusterings in use, is popped from the queue, then n
// label-pair reads run pipelined through the two stores, the pipeline drains,
// the sum is multiplied by 100 and a bit-serial divider divides it by n. the
// next command is popped once the divider is done. diagonal and out of range
// queries skip the scan and are answered at their pop, and writes are done at
// their pop in the back end.
// a two-deep command queue parts the front and back ends; busy means it is full.
// reset clears the queue, the sequencer and the register (to one clustering);
// the stores keep their contents and read undefined until written.
module weighted_coassociation_query_top #(
	parameter int ELEMENTS    = wcq_pkg::ELEMENTS_DEF,
	parameter int CLUSTERINGS = wcq_pkg::CLUSTERINGS_DEF,
	parameter int LABELS      = wcq_pkg::LABELS_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	output logic                           busy,
	input  wire wcq_pkg::wcq_in_t          item,
	output logic                           result_valid,
	output wcq_pkg::wcq_out_t              result,
	input  wire logic                      cfg_valid,
	output logic                           cfg_ready,
	input  wire logic [wcq_pkg::CFG_W-1:0] cfg_data
);
	import wcq_pkg::*;

	localparam int NCW = $clog2(CLUSTERINGS + 1);

	// front to queue
	logic       push;
	wcq_cmd_t   fcmd;
	// queue to back
	wcq_cmd_t   qcmd;
	wcq_qstat_t qstat;
	logic       pop;
	// effective clusterings from the register
	logic [NCW-1:0] n_eff;

	// queue full holds off new items
	assign busy = qstat.full;

	// front end: register, range checks, classification
	wcq_front #(
		.ELEMENTS   (ELEMENTS),
		.CLUSTERINGS(CLUSTERINGS),
		.LABELS     (LABELS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.item     (item),
		.full     (qstat.full),
		.push     (push),
		.cmd      (fcmd),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data),
		.n_eff    (n_eff)
	);

	// short command queue between the two ends
	wcq_queue u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.din   (fcmd),
		.pop   (pop),
		.dout  (qcmd),
		.stat  (qstat)
	);

	// back end: stores, scan over clusterings, percent and divide
	wcq_back #(
		.ELEMENTS   (ELEMENTS),
		.CLUSTERINGS(CLUSTERINGS),
		.LABELS     (LABELS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (qcmd),
		.stat        (qstat),
		.pop         (pop),
		.n_eff       (n_eff),
		.result_valid(result_valid),
		.result      (result)
	);

endmodule

`default_nettype wire

@@ hw/rtl/wcq_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module wcq_front #(
	parameter int ELEMENTS    = wcq_pkg::ELEMENTS_DEF,
	parameter int CLUSTERINGS = wcq_pkg::CLUSTERINGS_DEF,
	parameter int LABELS      = wcq_pkg::LABELS_DEF,
	localparam int NCW        = $clog2(CLUSTERINGS + 1)
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire wcq_pkg::wcq_in_t          item,
	input  wire logic                      full,
	output logic                           push,
	output wcq_pkg::wcq_cmd_t              cmd,
	input  wire logic                      cfg_valid,
	output logic                           cfg_ready,
	input  wire logic [wcq_pkg::CFG_W-1:0] cfg_data,
	output logic [NCW-1:0]                 n_eff
);
	import wcq_pkg::*;

	logic [CFG_W-1:0] cfg_q;
	logic             clus_ok;
	logic             lab_ok;
	logic             ea_ok;
	logic             eb_ok;
	logic             keep;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			cfg_q <= cfg_data;
		end
	end

	// zero counts as one, above the store size counts as the store size
	always_comb begin
		if (cfg_q == '0) begin
			n_eff = NCW'(1);
		end else if (32'(cfg_q) > CLUSTERINGS) begin
			n_eff = NCW'(CLUSTERINGS);
		end else begin
			n_eff = NCW'(cfg_q);
		end
	end

	assign clus_ok = 32'(item.clustering_index) < CLUSTERINGS;
	assign lab_ok  = (item.label != '0) && (32'(item.label) <= LABELS);
	assign ea_ok   = 32'(item.element_a) < ELEMENTS;
	assign eb_ok   = 32'(item.element_b) < ELEMENTS;

	always_comb begin
		cmd.op      = OP_QUERY;
		cmd.clus    = item.clustering_index;
		cmd.elem_a  = item.element_a;
		cmd.elem_b  = item.element_b;
		cmd.lab_idx = item.label - LAB_W'(1);
		cmd.weight  = (item.weight > WEIGHT_ONE) ? WEIGHT_ONE : item.weight;
		cmd.live    = (item.element_a != item.element_b) && ea_ok && eb_ok;
		keep        = 1'b0;
		unique case (item.action)
			ACT_LABEL: begin
				cmd.op = OP_LABEL;
				keep   = clus_ok && lab_ok && ea_ok;
			end
			ACT_WEIGHT: begin
				cmd.op = OP_WEIGHT;
				keep   = clus_ok && lab_ok;
			end
			ACT_QUERY: begin
				cmd.op = OP_QUERY;
				keep   = 1'b1;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	// dropped items are accepted but never queued
	assign push = start && !full && keep;

endmodule

`default_nettype wire

@@ hw/rtl/wcq_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none

module wcq_queue (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire wcq_pkg::wcq_cmd_t din,
	input  wire logic              pop,
	output wcq_pkg::wcq_cmd_t      dout,
	output wcq_pkg::wcq_qstat_t    stat
);
	import wcq_pkg::*;

	wcq_cmd_t       entry_q [QDEPTH];
	logic [QPW-1:0] wr_q;
	logic [QPW-1:0] rd_q;
	logic [QCW-1:0] cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == QPW'(QDEPTH - 1)) ? '0 : wr_q + QPW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == QPW'(QDEPTH - 1)) ? '0 : rd_q + QPW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + QCW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - QCW'(1);
			end
		end
	end

	assign dout       = entry_q[rd_q];
	assign stat.full  = (cnt_q == QCW'(QDEPTH));
	assign stat.empty = (cnt_q == '0);

endmodule

`default_nettype wire

@@ hw/rtl/wcq_back.sv @@
`timescale 1ns / 1ps
`default_nettype none

module wcq_back #(
	parameter int ELEMENTS    = wcq_pkg::ELEMENTS_DEF,
	parameter int CLUSTERINGS = wcq_pkg::CLUSTERINGS_DEF,
	parameter int LABELS      = wcq_pkg::LABELS_DEF,
	localparam int NCW        = $clog2(CLUSTERINGS + 1)
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire wcq_pkg::wcq_cmd_t   cmd,
	input  wire wcq_pkg::wcq_qstat_t stat,
	output logic                     pop,
	input  wire logic [NCW-1:0]      n_eff,
	output logic                     result_valid,
	output wcq_pkg::wcq_out_t        result
);
	import wcq_pkg::*;

	localparam int EW  = $clog2(ELEMENTS);
	localparam int CW  = (CLUSTERINGS > 1) ? $clog2(CLUSTERINGS) : 1;
	localparam int LW  = $clog2(LABELS);
	localparam int SW  = $clog2(CLUSTERINGS * int'(WEIGHT_ONE) + 1);
	localparam int PW  = SW + DIST_W;
	localparam int NW  = PW - WEIGHT_FRAC;
	localparam int RW  = NCW + 1;
	localparam int DCW = $clog2(NW + 1);
	localparam int KW  = NCW + 1;

	wcq_state_t state_q, state_d;

	logic [LW-1:0]     lmem [2**(CW+EW)];
	logic [WGT_W-1:0]  wmem [2**(CW+LW)];

	logic [CW-1:0]     k_q;
	logic [EW-1:0]     ea_q;
	logic [EW-1:0]     eb_q;
	logic [NCW-1:0]    n_q;
	logic [ELEM_W-1:0] row_q;
	logic [ELEM_W-1:0] col_q;

	logic              v_s1;
	logic [CW-1:0]     k_s1;
	logic [LW-1:0]     la_s1;
	logic [LW-1:0]     lb_s1;
	logic              v_s2;
	logic              hit_s2;
	logic [WGT_W-1:0]  w_s2;

	logic [SW-1:0]     sum_q;
	logic [PW-1:0]     prod;
	logic [NW-1:0]     num_q;
	logic [NW-1:0]     quo_q;
	logic [RW-1:0]     rem_q;
	logic [DCW-1:0]    dcnt_q;
	logic [RW-1:0]     trial;
	logic              ge;
	logic [RW-1:0]     rem_nx;
	logic [NW-1:0]     quo_nx;
	logic [DIST_W-1:0] dist_fin;

	logic              issue;
	logic              last_k;
	logic              take_query;
	logic              quick_res;
	logic              div_last;
	logic              res_valid_q;
	wcq_out_t          res_q;

	assign last_k     = (KW'(k_q) + KW'(1)) == KW'(n_q);
	assign take_query = pop && (cmd.op == OP_QUERY);
	assign quick_res  = take_query && !cmd.live;
	assign div_last   = (state_q == ST_DIV) && (dcnt_q == DCW'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		pop     = 1'b0;
		issue   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (!stat.empty) begin
					pop = 1'b1;
					if (cmd.op == OP_QUERY && cmd.live) begin
						state_d = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				issue = 1'b1;
				if (last_k) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!v_s1 && !v_s2) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				state_d = ST_DIV;
			end
			ST_DIV: begin
				if (dcnt_q == DCW'(1)) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// label store, two read ports for the pair
	always_ff @(posedge clk) begin
		if (pop && cmd.op == OP_LABEL) begin
			lmem[{CW'(cmd.clus), EW'(cmd.elem_a)}] <= LW'(cmd.lab_idx);
		end
		la_s1 <= lmem[{k_q, ea_q}];
		lb_s1 <= lmem[{k_q, eb_q}];
	end

	// weight store, read at the shared label
	always_ff @(posedge clk) begin
		if (pop && cmd.op == OP_WEIGHT) begin
			wmem[{CW'(cmd.clus), LW'(cmd.lab_idx)}] <= cmd.weight;
		end
		w_s2 <= wmem[{k_s1, la_s1}];
	end

	// restoring divide by n, one quotient bit a cycle
	assign prod     = PW'(sum_q) * PW'(PERCENT);
	assign trial    = {rem_q[RW-2:0], num_q[NW-1]};
	assign ge       = trial >= RW'(n_q);
	assign rem_nx   = ge ? (trial - RW'(n_q)) : trial;
	assign quo_nx   = {quo_q[NW-2:0], ge};
	assign dist_fin = (quo_nx > NW'(PERCENT)) ? PERCENT : quo_nx[DIST_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q         <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			dcnt_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (take_query) begin
				k_q <= '0;
			end else if (issue) begin
				k_q <= k_q + CW'(1);
			end
			v_s1 <= issue;
			v_s2 <= v_s1;
			if (state_q == ST_MUL) begin
				dcnt_q <= DCW'(NW);
			end else if (state_q == ST_DIV) begin
				dcnt_q <= dcnt_q - DCW'(1);
			end
			res_valid_q <= quick_res || div_last;
		end
	end

	always_ff @(posedge clk) begin
		if (take_query) begin
			ea_q  <= EW'(cmd.elem_a);
			eb_q  <= EW'(cmd.elem_b);
			n_q   <= n_eff;
			row_q <= cmd.elem_a;
			col_q <= cmd.elem_b;
			sum_q <= '0;
		end else if (v_s2 && hit_s2) begin
			sum_q <= sum_q + SW'(w_s2);
		end
		k_s1   <= k_q;
		hit_s2 <= (la_s1 == lb_s1);
		if (state_q == ST_MUL) begin
			num_q <= prod[PW-1:WEIGHT_FRAC];
			quo_q <= '0;
			rem_q <= '0;
		end else if (state_q == ST_DIV) begin
			num_q <= {num_q[NW-2:0], 1'b0};
			quo_q <= quo_nx;
			rem_q <= rem_nx;
		end
		if (quick_res) begin
			res_q.distance <= '0;
			res_q.pair_row <= cmd.elem_a;
			res_q.pair_col <= cmd.elem_b;
		end else if (div_last) begin
			res_q.distance <= dist_fin;
			res_q.pair_row <= row_q;
			res_q.pair_col <= col_q;
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

endmodule

`default_nettype wire

@@ hw/rtl/wcq_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module wcq_checker #(
	parameter int ELEMENTS = wcq_pkg::ELEMENTS_DEF
) (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              result_valid,
	input wire wcq_pkg::wcq_out_t result,
	input wire logic              cfg_ready
);
	import wcq_pkg::*;

	a_dist_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.distance <= PERCENT))
		else $error("distance above one hundred");

	a_diagonal: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && (result.pair_row == result.pair_col)) |-> (result.distance == '0))
		else $error("diagonal pair with nonzero distance");

	a_out_of_range: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && ((32'(result.pair_row) >= ELEMENTS) ||
		(32'(result.pair_col) >= ELEMENTS))) |-> (result.distance == '0))
		else $error("out of range pair with nonzero distance");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		$past(arst_n) |-> cfg_ready)
		else $error("config channel not ready");

endmodule

bind weighted_coassociation_query_top wcq_checker #(
	.ELEMENTS(ELEMENTS)
) u_wcq_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.result_valid(result_valid),
	.result      (result),
	.cfg_ready   (cfg_ready)
);

`default_nettype wire
